>>> design/lhq_pkg.sv
// Shared constants for the log2 latency histogram core.
`default_nettype none

package lhq_pkg;

    // Histogram geometry
    localparam int PHASES      = 8;
    localparam int BUCKETS     = 64;
    localparam int COUNT_WIDTH = 32;

    localparam int ENTRIES = PHASES * BUCKETS;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int BIDX_W  = $clog2(BUCKETS);
    localparam int STEP_W  = $clog2(BUCKETS + 1);
    localparam int SUM_W   = COUNT_WIDTH + $clog2(BUCKETS);
    localparam int THR_W   = SUM_W + 5;

    // Port field widths
    localparam int PHASE_W  = 3;
    localparam int TICK_W   = 48;
    localparam int FREQ_W   = 32;
    localparam int SAMPLE_W = 38;
    localparam int BKT_W    = 6;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10_000_000;

    // Tick to nanosecond conversion
    localparam int NS_W = 30;
    localparam logic [NS_W-1:0] NS_PER_S = 30'd1_000_000_000;
    localparam int MAG_W  = TICK_W - 1;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PRD_W  = LO_W + NS_W;
    localparam int DVD_W  = MAG_W + NS_W;
    localparam int DCNT_W = $clog2(DVD_W);

    // Operation codes
    localparam logic OP_RECORD  = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [SUM_W-1:0]       t_sum;

endpackage

`default_nettype wire

>>> design/log2_latency_histogram_quantile_core.sv
// Top level: per-phase log2 latency histogram with median and p95 readout.
`default_nettype none

// Keeps PHASES x BUCKETS saturating counters in one single-port synchronous
// RAM (one read, one write per cycle, registered read data). A record
// transaction converts ticks to ns as floor(ticks*1e9/tick_frequency),
// picks bucket ceil(log2 ns) capped at the last bucket, and does a
// read-modify-write of that counter. Records with negative or zero ticks,
// or while tick_frequency is zero, are dropped on acceptance. A consume
// transaction returns the phase total plus the median and p95 bucket and
// clears the phase. Steps: a kept record passes through accept, a low-half
// and a high-half multiply, the bit-serial divider, a read and a write; the
// divider is the longest step. A consume makes two sweeps over the phase
// through the single RAM port (sum, then scan and clear) and then loads the
// result. One transaction is in work at a time. A finished result sits in
// its own output register, so the next input can be taken while it waits.
// After reset the RAM is cleared by a pass over every entry during which no
// input is accepted; configuration writes are taken at any time and should
// only be issued while idle.
module log2_latency_histogram_quantile_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_we,
    input  wire [lhq_pkg::FREQ_W-1:0]       i_cfg_wdata,
    // input channel
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire                             i_op,
    input  wire [lhq_pkg::PHASE_W-1:0]      i_phase,
    input  wire signed [lhq_pkg::TICK_W-1:0] i_tick_count,
    // output channel
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [lhq_pkg::SAMPLE_W-1:0]    o_sample_count,
    output logic [lhq_pkg::BKT_W-1:0]       o_median_bucket,
    output logic [lhq_pkg::BKT_W-1:0]       o_p95_bucket
);
    import lhq_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL0  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_SCAN  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // Control
    logic [3:0]        r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [STEP_W-1:0] r_step;
    logic [DCNT_W-1:0] r_div_cnt;
    logic              r_out_vld;
    logic [FREQ_W-1:0] r_freq;

    // Datapath
    logic [PHASE_W-1:0] r_phase;
    logic [MAG_W-1:0]   r_mag;
    logic [DVD_W-1:0]   r_dvd;
    logic [FREQ_W-1:0]  r_rem;
    logic               r_seen;
    logic               r_sticky;
    logic [DCNT_W-1:0]  r_lead;
    t_sum               r_total;
    t_sum               r_cum;
    logic [THR_W-1:0]   r_thr95;
    logic               r_med_found;
    logic               r_p95_found;
    logic [BIDX_W-1:0]  r_med;
    logic [BIDX_W-1:0]  r_p95;
    logic [SAMPLE_W-1:0] r_osc;
    logic [BKT_W-1:0]   r_omed;
    logic [BKT_W-1:0]   r_op95;

    // Bucket RAM
    t_count            mem [ENTRIES];
    t_count            r_rdata;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    t_count            mem_wdata;

    // Combinational helpers
    logic               in_acc;
    logic               rec_drop;
    logic               in_phase_ok;
    logic [LO_W-1:0]    mul_a;
    logic [PRD_W-1:0]   mul_p;
    logic [FREQ_W:0]    rem_sh;
    logic [FREQ_W+1:0]  div_diff;
    logic               qbit;
    logic [BIDX_W-1:0]  bucket_c;
    logic [ADDR_W-1:0]  row_base;
    t_sum               cum_n;
    logic [THR_W-1:0]   cum_x20;
    logic               hit50;
    logic               hit95;
    logic [BIDX_W-1:0]  data_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_phase_ok = (32'(i_phase) < PHASES);
    assign rec_drop    = !in_phase_ok || i_tick_count[TICK_W-1]
                         || (i_tick_count == '0) || (r_freq == '0);

    // Shared multiplier: low half of the magnitude, then the high half.
    assign mul_a = (r_state == S_MUL0) ? r_mag[LO_W-1:0]
                                       : LO_W'(r_mag[MAG_W-1:LO_W]);
    assign mul_p = PRD_W'(mul_a) * PRD_W'(NS_PER_S);

    // Restoring divider, one quotient bit per cycle.
    assign rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign div_diff = {1'b0, rem_sh} - {2'b00, r_freq};
    assign qbit     = !div_diff[FREQ_W+1];

    // ceil(log2 q): leading one position, plus one if any lower bit is set.
    always_comb begin
        if (!r_seen) begin
            bucket_c = '0;
        end else if (r_lead >= DCNT_W'(BUCKETS - 1)) begin
            bucket_c = BIDX_W'(BUCKETS - 1);
        end else begin
            bucket_c = BIDX_W'(r_lead) + BIDX_W'(r_sticky);
        end
    end

    assign row_base = ADDR_W'(ADDR_W'(r_phase) * ADDR_W'(BUCKETS));

    // Quantile tests: cum >= ceil(total*q/100) <=> 100*cum >= q*total.
    assign cum_n    = r_cum + SUM_W'(r_rdata);
    assign cum_x20  = (THR_W'(cum_n) << 4) + (THR_W'(cum_n) << 2);
    assign hit50    = ({cum_n, 1'b0} >= {1'b0, r_total});
    assign hit95    = (cum_x20 >= r_thr95);
    assign data_idx = BIDX_W'(r_step - STEP_W'(1));

    // RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = row_base + ADDR_W'(r_step[BIDX_W-1:0]);
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            S_RD: begin
                mem_re   = 1'b1;
                mem_addr = row_base + ADDR_W'(bucket_c);
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_addr  = row_base + ADDR_W'(bucket_c);
                mem_wdata = (r_rdata == '1) ? r_rdata : r_rdata + t_count'(1);
            end
            S_SUM: begin
                mem_re = (r_step < STEP_W'(BUCKETS));
            end
            S_SCAN: begin
                // read old value and clear in the same cycle
                mem_re = (r_step < STEP_W'(BUCKETS));
                mem_we = (r_step < STEP_W'(BUCKETS));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_step     <= '0;
            r_div_cnt  <= '0;
            r_out_vld  <= 1'b0;
            r_freq     <= FREQ_RESET;
        end else begin
            if (i_cfg_we) begin
                r_freq <= i_cfg_wdata;
            end
            // in the done state the reload below covers the drain
            if (r_out_vld && i_out_ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_phase     <= i_phase;
                        r_mag       <= i_tick_count[MAG_W-1:0];
                        r_step      <= '0;
                        r_total     <= '0;
                        r_cum       <= '0;
                        r_med_found <= 1'b0;
                        r_p95_found <= 1'b0;
                        r_med       <= '0;
                        r_p95       <= '0;
                        if (i_op == OP_CONSUME) begin
                            r_state <= in_phase_ok ? S_SUM : S_DONE;
                        end else if (!rec_drop) begin
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_MUL0: begin
                    r_dvd   <= DVD_W'(mul_p);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_dvd     <= r_dvd + (DVD_W'(mul_p) << LO_W);
                    r_rem     <= '0;
                    r_div_cnt <= DCNT_W'(DVD_W - 1);
                    r_seen    <= 1'b0;
                    r_sticky  <= 1'b0;
                    r_lead    <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_dvd <= r_dvd << 1;
                    r_rem <= qbit ? div_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
                    if (qbit) begin
                        if (!r_seen) begin
                            r_seen <= 1'b1;
                            r_lead <= r_div_cnt;
                        end else begin
                            r_sticky <= 1'b1;
                        end
                    end
                    r_div_cnt <= r_div_cnt - DCNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    // data for bucket step-1 is in r_rdata
                    if (r_step != '0) begin
                        r_total <= r_total + SUM_W'(r_rdata);
                    end
                    if (r_step == STEP_W'(BUCKETS)) begin
                        r_step  <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_SCAN: begin
                    if (r_step == '0) begin
                        r_thr95 <= (THR_W'(r_total) << 4) + (THR_W'(r_total) << 1)
                                   + THR_W'(r_total);
                        r_med   <= BIDX_W'(BUCKETS - 1);
                        r_p95   <= BIDX_W'(BUCKETS - 1);
                    end else begin
                        r_cum <= cum_n;
                        if (!r_med_found && hit50) begin
                            r_med_found <= 1'b1;
                            r_med       <= data_idx;
                        end
                        if (!r_p95_found && hit95) begin
                            r_p95_found <= 1'b1;
                            r_p95       <= data_idx;
                        end
                    end
                    if (r_step == STEP_W'(BUCKETS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    // hand off once the output register is free
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld <= 1'b1;
                        r_osc     <= SAMPLE_W'(r_total);
                        r_omed    <= BKT_W'(r_med);
                        r_op95    <= BKT_W'(r_p95);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sample_count  = r_osc;
    assign o_median_bucket = r_omed;
    assign o_p95_bucket    = r_op95;

    // Checks
    a_med_le_p95: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_median_bucket <= o_p95_bucket))
        else $error("median bucket above p95 bucket");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_sample_count == '0)) |->
            ((o_median_bucket == '0) && (o_p95_bucket == '0)))
        else $error("empty phase returned nonzero bucket");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> ((r_state == S_CLEAR) || (r_state == S_IDLE))
            && !o_out_valid)
        else $error("activity during the clearing pass");

endmodule

`default_nettype wire
